/* hdl/pf_pkg.sv */
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and key-square helpers for the Playfair encryptor.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int SqDim = 5;
  localparam int CodeW = 5;
  localparam int RowW  = SqDim * CodeW;

  localparam logic [CodeW-1:0] CodeI = 5'd8;
  localparam logic [CodeW-1:0] CodeJ = 5'd9;

  // configuration register indexes
  localparam logic [2:0] RegRow0 = 3'd0;
  localparam logic [2:0] RegRow1 = 3'd1;
  localparam logic [2:0] RegRow2 = 3'd2;
  localparam logic [2:0] RegRow3 = 3'd3;
  localparam logic [2:0] RegRow4 = 3'd4;
  localparam logic [2:0] RegPad  = 3'd5;

  typedef logic [SqDim-1:0][RowW-1:0] key_sq_t;

  // square MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC
  localparam key_sq_t KeyReset = {25'd2149955, 25'd6848868, 25'd25942713,
                                  25'd17283508, 25'd10755244};
  localparam logic [CodeW-1:0] PadReset = 5'd23;

  typedef struct packed {
    logic [CodeW-1:0] a;
    logic [CodeW-1:0] b;
    logic             mark;
  } pair_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } loc_t;

  function automatic logic [CodeW-1:0] cell_at(key_sq_t sq, logic [2:0] row,
                                               logic [2:0] col);
    return sq[row][CodeW*col +: CodeW];
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == 3'(SqDim-1)) ? 3'd0 : v + 3'd1;
  endfunction

  // First match in row order; a code not in the square sits at row 0, column 0.
  function automatic loc_t locate(key_sq_t sq, logic [CodeW-1:0] code);
    logic [CodeW-1:0] key;
    loc_t             loc;
    key = (code == CodeJ) ? CodeI : code;
    loc = '0;
    for (int r = SqDim-1; r >= 0; r--) begin
      for (int c = SqDim-1; c >= 0; c--) begin
        if (sq[r][CodeW*c +: CodeW] == key) begin
          loc.row = 3'(r);
          loc.col = 3'(c);
        end
      end
    end
    return loc;
  endfunction

endpackage

/* hdl/pf_cipher.sv */
// ----------------------------------------------------------------------------
// pf_cipher
// Enciphers one digram against the key square: row shift, column shift or
// rectangle swap.
// ----------------------------------------------------------------------------
module pf_cipher import pf_pkg::*; (
  input  key_sq_t          key_sq,
  input  pair_t            pair,
  output logic [CodeW-1:0] x,
  output logic [CodeW-1:0] y
);

  loc_t loc_a;
  loc_t loc_b;

  assign loc_a = locate(key_sq, pair.a);
  assign loc_b = locate(key_sq, pair.b);

  always_comb begin
    if (loc_a.row == loc_b.row) begin
      x = cell_at(key_sq, loc_a.row, wrap_inc(loc_a.col));
      y = cell_at(key_sq, loc_b.row, wrap_inc(loc_b.col));
    end else if (loc_a.col == loc_b.col) begin
      x = cell_at(key_sq, wrap_inc(loc_a.row), loc_a.col);
      y = cell_at(key_sq, wrap_inc(loc_b.row), loc_b.col);
    end else begin
      x = cell_at(key_sq, loc_a.row, loc_b.col);
      y = cell_at(key_sq, loc_b.row, loc_a.col);
    end
  end

endmodule

/* hdl/playfair_digram_encryptor.sv */
// A letter pair is held in the pair stage (s1_pair) after the transfer of the
// byte that completes it, then moves to the output register (ob), which shows
// its first cipher letter; the second letter follows. Cipher letters leave at
// one per cycle at the output port while out_ready is high.
// Bytes that close no pair are taken every cycle while the pair stage is free.
// Reset (rst, synchronous): clears pending letter and pipeline, reloads key.
// ----------------------------------------------------------------------------
// playfair_digram_encryptor
// Byte stream in, Playfair cipher letters out, key square in config regs.
// ----------------------------------------------------------------------------
module playfair_digram_encryptor import pf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      char_in,
  input  logic            end_of_message,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [6:0]      cipher_char,
  output logic            last_out,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [RowW-1:0] cfg_data
);

  key_sq_t          key_sq;
  logic [CodeW-1:0] pad;

  logic             pend_valid;
  logic [CodeW-1:0] pend_letter;
  logic             pend_valid_next;
  logic [CodeW-1:0] pend_letter_next;

  logic             is_upper;
  logic             is_lower;
  logic             is_letter;
  logic [CodeW-1:0] code;
  logic             a_vld;
  logic             b_vld;
  pair_t            pair_a;
  pair_t            pair_b;

  logic [1:0]       s1_cnt;
  pair_t            s1_pair [2];
  logic             pair_move;
  logic             in_fire;
  logic             out_fire;

  logic [1:0]       ob_cnt;
  logic [CodeW-1:0] ob_x;
  logic [CodeW-1:0] ob_y;
  logic             ob_mark;
  logic [CodeW-1:0] ciph_x;
  logic [CodeW-1:0] ciph_y;

  // --- letter decode and digram forming ---
  assign is_upper  = (char_in >= 8'd65) && (char_in <= 8'd90);
  assign is_lower  = (char_in >= 8'd97) && (char_in <= 8'd122);
  assign is_letter = is_upper || is_lower;
  assign code      = is_upper ? 5'(char_in - 8'd65) : 5'(char_in - 8'd97);

  always_comb begin
    pend_valid_next  = pend_valid;
    pend_letter_next = pend_letter;
    a_vld            = 1'b0;
    pair_a           = '{a: pend_letter, b: code, mark: 1'b0};
    if (is_letter) begin
      if (!pend_valid) begin
        pend_valid_next  = 1'b1;
        pend_letter_next = code;
      end else if (pend_letter == code) begin
        // double letter: pad goes in, repeated letter stays pending
        a_vld    = 1'b1;
        pair_a.b = pad;
      end else begin
        a_vld           = 1'b1;
        pend_valid_next = 1'b0;
      end
    end
    b_vld  = end_of_message && pend_valid_next;
    pair_b = '{a: pend_letter_next, b: pad, mark: 1'b1};
    if (b_vld) begin
      pend_valid_next = 1'b0;
    end
  end

  // --- handshakes ---
  assign out_valid = (ob_cnt != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign pair_move = (s1_cnt != 2'd0) &&
                     ((ob_cnt == 2'd0) || ((ob_cnt == 2'd1) && out_ready));
  assign in_ready  = (s1_cnt == 2'd0) || ((s1_cnt == 2'd1) && pair_move);
  assign in_fire   = in_valid && in_ready;

  // --- control state ---
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      s1_cnt     <= 2'd0;
      ob_cnt     <= 2'd0;
      key_sq     <= KeyReset;
      pad        <= PadReset;
    end else begin
      if (in_fire) begin
        pend_valid <= pend_valid_next;
        s1_cnt     <= {1'b0, a_vld} + {1'b0, b_vld};
      end else if (pair_move) begin
        s1_cnt <= s1_cnt - 2'd1;
      end
      if (pair_move) begin
        ob_cnt <= 2'd2;
      end else if (out_fire) begin
        ob_cnt <= ob_cnt - 2'd1;
      end
      if (cfg_we) begin
        unique case (cfg_index) inside
          RegRow0, RegRow1, RegRow2, RegRow3, RegRow4: key_sq[cfg_index] <= cfg_data;
          RegPad:  pad <= cfg_data[CodeW-1:0];
          default: ;
        endcase
      end
    end
  end

  // --- payload ---
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_letter <= pend_letter_next;
      s1_pair[0]  <= a_vld ? pair_a : pair_b;
      s1_pair[1]  <= pair_b;
    end else if (pair_move) begin
      s1_pair[0] <= s1_pair[1];
    end
    if (pair_move) begin
      ob_x    <= ciph_x;
      ob_y    <= ciph_y;
      ob_mark <= s1_pair[0].mark;
    end
  end

  pf_cipher u_cipher (
    .key_sq (key_sq),
    .pair   (s1_pair[0]),
    .x      (ciph_x),
    .y      (ciph_y)
  );

  assign cipher_char = 7'd65 + {2'b00, (ob_cnt == 2'd2) ? ob_x : ob_y};
  assign last_out    = (ob_cnt == 2'd1) && ob_mark;

endmodule

/* hdl/pf_checker.sv */
// ----------------------------------------------------------------------------
// pf_checker
// Port-level checks on the Playfair encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module pf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] cipher_char,
  input logic       last_out
);

  // nothing left over after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_char) && $stable(last_out))
    else $error("stalled result changed");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cipher_char >= 7'd65) && (cipher_char <= 7'd96))
    else $error("cipher letter out of range");

  // a marked letter closes a pair, so the next letter opens one
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> !(out_valid && last_out))
    else $error("two marked letters in a row");

endmodule

bind playfair_digram_encryptor pf_checker u_pf_checker (.*);

/* test/tb_playfair_digram_encryptor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_digram_encryptor
// Drives byte streams through the encryptor under several key squares and pad
// letters. It predicts every cipher letter and checks each output transfer.
// ----------------------------------------------------------------------------
module tb_playfair_digram_encryptor;
  import pf_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int SettleCycles = 12;

  // out-of-range register slots, writes there must be ignored
  localparam logic [2:0] RegSpareA = 3'd6;
  localparam logic [2:0] RegSpareB = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
  } msg_byte_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } cipher_res_t;

  typedef enum logic [1:0] {RecvOpen, RecvRandom, RecvSparse, RecvBursty} recv_mode_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      char_in = '0;
  logic            end_of_message = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [6:0]      cipher_char;
  logic            last_out;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_index = '0;
  logic [RowW-1:0] cfg_data = '0;

  msg_byte_t   msg_q[$];
  cipher_res_t cipher_q[$];
  msg_byte_t   next_item;
  cipher_res_t want;

  // predictor state
  logic [RowW-1:0]  key_rows [SqDim];
  logic [CodeW-1:0] pad_code;
  logic             pend_valid = 1'b0;
  logic [CodeW-1:0] pend_code = '0;
  logic [CodeW-1:0] prev_code = '0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int err_count = 0;
  logic [7:0] recv_cyc = '0;
  recv_mode_t recv_mode = RecvOpen;

  playfair_digram_encryptor dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cipher_char    (cipher_char),
    .last_out       (last_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 100) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    err_count++;
  endtask

  function automatic logic [CodeW-1:0] sq_code(int r, int c);
    return key_rows[r][CodeW*c +: CodeW];
  endfunction

  // first match in row order; J is searched as I; missing code lands at 0,0
  task automatic find_code(input logic [CodeW-1:0] code, output int row, output int col);
    logic [CodeW-1:0] target;
    bit               found;
    target = (code == CodeJ) ? CodeI : code;
    row = 0;
    col = 0;
    found = 1'b0;
    for (int r = 0; r < SqDim && !found; r++) begin
      for (int c = 0; c < SqDim && !found; c++) begin
        if (sq_code(r, c) == target) begin
          row = r;
          col = c;
          found = 1'b1;
        end
      end
    end
  endtask

  task automatic encipher_pair(input logic [CodeW-1:0] a, input logic [CodeW-1:0] b,
                               input logic mark);
    int r1, c1, r2, c2;
    logic [CodeW-1:0] x, y;
    find_code(a, r1, c1);
    find_code(b, r2, c2);
    if (r1 == r2) begin
      x = sq_code(r1, (c1 + 1) % SqDim);
      y = sq_code(r2, (c2 + 1) % SqDim);
    end else if (c1 == c2) begin
      x = sq_code((r1 + 1) % SqDim, c1);
      y = sq_code((r2 + 1) % SqDim, c2);
    end else begin
      x = sq_code(r1, c2);
      y = sq_code(r2, c1);
    end
    cipher_q.push_back('{ch: 7'(65 + x), last: 1'b0});
    cipher_q.push_back('{ch: 7'(65 + y), last: mark});
  endtask

  task automatic predict_cipher(input logic [7:0] ch, input logic eom);
    bit               is_letter;
    logic [CodeW-1:0] code;
    is_letter = 1'b0;
    code = '0;
    if (ch >= 8'd65 && ch <= 8'd90) begin
      is_letter = 1'b1;
      code = 5'(ch - 8'd65);
    end else if (ch >= 8'd97 && ch <= 8'd122) begin
      is_letter = 1'b1;
      code = 5'(ch - 8'd97);
    end
    if (is_letter) begin
      if (!pend_valid) begin
        pend_valid = 1'b1;
        pend_code = code;
      end else if (pend_code == code) begin
        // double letter: pad fills in, repeated letter stays pending
        encipher_pair(pend_code, pad_code, 1'b0);
      end else begin
        encipher_pair(pend_code, code, 1'b0);
        pend_valid = 1'b0;
      end
    end
    if (eom && pend_valid) begin
      encipher_pair(pend_code, pad_code, 1'b1);
      pend_valid = 1'b0;
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_cipher(char_in, end_of_message);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (msg_q.size() > 0) begin
          next_item = msg_q.pop_front();
          char_in <= next_item.ch;
          end_of_message <= next_item.eom;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transfer, then pick the next ready value
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result char %h last %b", cipher_char, last_out));
        end else begin
          want = cipher_q.pop_front();
          if (cipher_char !== want.ch) begin
            report_mismatch($sformatf("cipher_char %h, want %h", cipher_char, want.ch));
          end
          if (last_out !== want.last) begin
            report_mismatch($sformatf("last_out %b, want %b", last_out, want.last));
          end
        end
      end
      recv_cyc <= recv_cyc + 8'd1;
      if (recv_cyc[6:0] == 7'd0) begin
        recv_mode <= recv_mode_t'($urandom_range(0, 3));
      end
      case (recv_mode)
        RecvOpen: out_ready <= 1'b1;
        RecvRandom: out_ready <= 1'($urandom_range(0, 1));
        RecvSparse: out_ready <= (recv_cyc[1:0] == 2'd0);
        default: begin
          if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
              stall_left <= $urandom_range(4, 12);
            end
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] ch, input logic eom);
    msg_q.push_back('{ch: ch, eom: eom});
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [RowW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx <= RegRow4) begin
      key_rows[idx] = data;
    end else if (idx == RegPad) begin
      pad_code = data[CodeW-1:0];
    end
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // proper key: 25 distinct letters, J left out
  task automatic load_shuffled_key();
    logic [CodeW-1:0] codes [25];
    logic [CodeW-1:0] tmp;
    logic [RowW-1:0]  row;
    int k, j;
    k = 0;
    for (int v = 0; v < 26; v++) begin
      if (v != int'(CodeJ)) begin
        codes[k] = 5'(v);
        k++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = codes[i];
      codes[i] = codes[j];
      codes[j] = tmp;
    end
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        row[CodeW*c +: CodeW] = codes[r*SqDim + c];
      end
      write_reg(3'(r), row);
    end
  endtask

  // mostly letters in both cases, with doubles, pad letters, stray bytes
  task automatic push_random_text(input int count);
    int sel;
    logic [CodeW-1:0] code;
    logic [7:0] ch;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      code = 5'($urandom_range(0, 25));
      if (sel < 14) begin
        code = prev_code;
      end else if (sel < 20 && pad_code <= 5'd25) begin
        code = pad_code;
      end
      if (sel >= 90) begin
        ch = 8'($urandom_range(0, 255));
      end else begin
        ch = (sel[0] ? 8'd97 : 8'd65) + 8'(code);
        prev_code = code;
      end
      push_byte(ch, $urandom_range(0, 9) == 0);
    end
  endtask

  // hold until every expected result is in, then let the pipeline settle
  task automatic drain();
    do @(negedge clk); while (msg_q.size() > 0 || in_valid || cipher_q.size() > 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    for (int r = 0; r < SqDim; r++) begin
      key_rows[r] = KeyReset[r];
    end
    pad_code = PadReset;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset key square and pad
    push_byte("h", 1'b0);
    push_byte("e", 1'b0);
    push_byte("L", 1'b0);
    push_byte("L", 1'b0);
    push_byte("L", 1'b0);
    push_byte("O", 1'b0);
    push_byte(8'h31, 1'b0);
    push_byte("J", 1'b0);
    push_byte("I", 1'b0);
    push_byte("X", 1'b1);
    push_byte("M", 1'b0);
    push_byte("U", 1'b0);
    push_byte("a", 1'b0);
    push_byte("B", 1'b1);
    push_byte("Q", 1'b0);
    push_byte(".", 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h5B, 1'b0);
    push_byte(8'h60, 1'b0);
    push_byte(8'h7B, 1'b0);
    push_byte("z", 1'b0);
    push_byte("Z", 1'b1);
    push_random_text(60);
    drain();

    load_shuffled_key();
    write_reg(RegPad, RowW'($urandom_range(0, 25)));
    end_writes();
    push_random_text(110);
    drain();

    // every cell A, pad A
    for (int r = 0; r < SqDim; r++) write_reg(3'(r), '0);
    write_reg(RegPad, '0);
    end_writes();
    push_random_text(40);
    drain();

    // every cell 31, pad 31 with upper bits set
    for (int r = 0; r < SqDim; r++) write_reg(3'(r), '1);
    write_reg(RegPad, '1);
    end_writes();
    push_random_text(40);
    drain();

    // arbitrary cells: duplicates and codes outside the alphabet
    for (int r = 0; r < SqDim; r++) write_reg(3'(r), RowW'($urandom));
    write_reg(RegPad, RowW'($urandom));
    write_reg(RegSpareA, RowW'($urandom));
    write_reg(RegSpareB, RowW'($urandom));
    end_writes();
    push_random_text(110);
    drain();

    load_shuffled_key();
    write_reg(RegPad, RowW'(25));
    end_writes();
    push_random_text(110);
    drain();

    if (cipher_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", cipher_q.size()));
    end
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pf_pkg.sv
hdl/pf_cipher.sv
hdl/playfair_digram_encryptor.sv
hdl/pf_checker.sv
test/tb_playfair_digram_encryptor.sv
